FILE: sv/mqtt_ch_pkg.sv
package mqtt_ch_pkg;

  // Fixed first byte value of the CONNECT header, field byte counts and length width
  localparam logic [7:0] CONNECT_FIRST_BYTE = 8'h10;
  localparam logic [2:0] VBI_MAX_BYTES      = 3'd4;
  localparam logic [2:0] NAME_LAST_INDEX    = 3'd5;
  localparam logic [2:0] KEEP_ALIVE_BYTES   = 3'd2;
  localparam int         LEN_W              = 28;

  // Parse phase; DRAIN skips bytes after the result until the packet ends
  typedef enum logic [3:0] {
    PH_FIRST   = 4'd0,
    PH_REMLEN  = 4'd1,
    PH_NAME    = 4'd2,
    PH_VERSION = 4'd3,
    PH_FLAGS   = 4'd4,
    PH_KEEP    = 4'd5,
    PH_PROPLEN = 4'd6,
    PH_DRAIN   = 4'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_FIRST = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_BAD_NAME  = 3'd3,
    ST_RESERVED  = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         version;
    logic [7:0]         flags;
    logic [15:0]        keep_alive;
    logic [LEN_W-1:0]   rem_len;
    logic [LEN_W-1:0]   prop_len;
  } result_t;

  // Expected protocol name bytes: 0, 4, 'M', 'Q', 'T', 'T' (index wraps mod 6)
  function automatic logic [7:0] name_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h00;
      3'd1:    v = 8'h04;
      3'd2:    v = 8'h4D;
      3'd3:    v = 8'h51;
      3'd4:    v = 8'h54;
      3'd5:    v = 8'h54;
      3'd6:    v = 8'h00;
      default: v = 8'h04;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/mqtt_connect_header_parser.sv
// CONNECT header parser, one packet byte per item.
// Each result is registered into the output register, or into the skid entry while the output is held.
// Throughput: one byte per cycle; an output register plus one skid entry
// decouple the sides, so item_ready drops only while the skid entry is full.
// Reset (rst, synchronous): parser waits for a first byte, no result pending.
module mqtt_connect_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  status,
  output logic [7:0]  protocol_version,
  output logic        clean_start,
  output logic        will_present,
  output logic [1:0]  will_qos,
  output logic        will_retain,
  output logic        password_present,
  output logic        username_present,
  output logic [15:0] keep_alive_seconds,
  output logic [27:0] rem_length,
  output logic [27:0] prop_length
);

  localparam int LW = mqtt_ch_pkg::LEN_W;

  // Parse state
  mqtt_ch_pkg::phase_t phase, phase_next;
  logic [2:0]          cnt, cnt_next;
  logic                name_bad, name_bad_next;
  logic [LW-1:0]       acc, acc_next;
  logic [LW-1:0]       rem_len, rem_len_next;
  logic [7:0]          version, version_next;
  logic [7:0]          flags, flags_next;
  logic [15:0]         keep, keep_next;

  // Result path
  mqtt_ch_pkg::result_t out_q, skid_q, res;
  logic                 out_valid, skid_valid;
  logic                 item_fire, out_fire, res_fire;
  mqtt_ch_pkg::status_t res_status;

  logic [LW-1:0] acc_merge;
  logic          name_bad_now;

  assign item_ready = !skid_valid;
  assign item_fire  = item_valid && item_ready;
  assign out_fire   = out_valid && result_ready;

  // Variable byte integer: OR in seven bits at the current group
  always_comb begin
    acc_merge = acc;
    case (cnt[1:0])
      2'd0:    acc_merge[6:0]   = acc[6:0]   | byte_value[6:0];
      2'd1:    acc_merge[13:7]  = acc[13:7]  | byte_value[6:0];
      2'd2:    acc_merge[20:14] = acc[20:14] | byte_value[6:0];
      default: acc_merge[27:21] = acc[27:21] | byte_value[6:0];
    endcase
  end

  assign name_bad_now = name_bad || (byte_value != mqtt_ch_pkg::name_byte(cnt));

  // Result decision for the byte at the input
  always_comb begin
    res_fire   = 1'b0;
    res_status = mqtt_ch_pkg::ST_OK;
    unique case (phase)
      mqtt_ch_pkg::PH_FIRST: begin
        if (byte_value != mqtt_ch_pkg::CONNECT_FIRST_BYTE) begin
          res_fire = 1'b1; res_status = mqtt_ch_pkg::ST_BAD_FIRST;
        end else if (last_byte) begin
          res_fire = 1'b1; res_status = mqtt_ch_pkg::ST_TRUNCATED;
        end
      end
      mqtt_ch_pkg::PH_REMLEN: begin
        if (cnt >= mqtt_ch_pkg::VBI_MAX_BYTES) begin
          res_fire = 1'b1; res_status = mqtt_ch_pkg::ST_TOO_LONG;
        end else if (last_byte) begin
          res_fire = 1'b1; res_status = mqtt_ch_pkg::ST_TRUNCATED;
        end
      end
      mqtt_ch_pkg::PH_NAME: begin
        if (last_byte) begin
          res_fire = 1'b1; res_status = mqtt_ch_pkg::ST_TRUNCATED;
        end else if (cnt >= mqtt_ch_pkg::NAME_LAST_INDEX && name_bad_now) begin
          res_fire = 1'b1; res_status = mqtt_ch_pkg::ST_BAD_NAME;
        end
      end
      mqtt_ch_pkg::PH_VERSION, mqtt_ch_pkg::PH_KEEP: begin
        if (last_byte) begin
          res_fire = 1'b1; res_status = mqtt_ch_pkg::ST_TRUNCATED;
        end
      end
      mqtt_ch_pkg::PH_FLAGS: begin
        if (last_byte) begin
          res_fire = 1'b1; res_status = mqtt_ch_pkg::ST_TRUNCATED;
        end else if (byte_value[0]) begin
          res_fire = 1'b1; res_status = mqtt_ch_pkg::ST_RESERVED;
        end
      end
      mqtt_ch_pkg::PH_PROPLEN: begin
        if (cnt >= mqtt_ch_pkg::VBI_MAX_BYTES) begin
          res_fire = 1'b1; res_status = mqtt_ch_pkg::ST_TOO_LONG;
        end else if (!byte_value[7]) begin
          res_fire = 1'b1; res_status = mqtt_ch_pkg::ST_OK;
        end else if (last_byte) begin
          res_fire = 1'b1; res_status = mqtt_ch_pkg::ST_TRUNCATED;
        end
      end
      default: begin
        res_fire = 1'b0;
      end
    endcase

    // Error results carry zeros in every other field
    res        = '0;
    res.status = res_status;
    if (res_status == mqtt_ch_pkg::ST_OK) begin
      res.version    = version;
      res.flags      = flags;
      res.keep_alive = keep;
      res.rem_len    = rem_len;
      res.prop_len   = acc_merge;
    end
  end

  // Next parse state
  always_comb begin
    phase_next    = phase;
    cnt_next      = cnt;
    name_bad_next = name_bad;
    acc_next      = acc;
    rem_len_next  = rem_len;
    version_next  = version;
    flags_next    = flags;
    keep_next     = keep;
    if (item_fire) begin
      unique case (phase)
        mqtt_ch_pkg::PH_FIRST: begin
          phase_next = mqtt_ch_pkg::PH_REMLEN;
          cnt_next   = '0;
          acc_next   = '0;
        end
        mqtt_ch_pkg::PH_REMLEN: begin
          acc_next = acc_merge;
          cnt_next = cnt + 3'd1;
          if (!byte_value[7]) begin
            rem_len_next  = acc_merge;
            phase_next    = mqtt_ch_pkg::PH_NAME;
            cnt_next      = '0;
            name_bad_next = 1'b0;
          end
        end
        mqtt_ch_pkg::PH_NAME: begin
          name_bad_next = name_bad_now;
          if (cnt >= mqtt_ch_pkg::NAME_LAST_INDEX) begin
            phase_next = mqtt_ch_pkg::PH_VERSION;
          end else begin
            cnt_next = cnt + 3'd1;
          end
        end
        mqtt_ch_pkg::PH_VERSION: begin
          version_next = byte_value;
          phase_next   = mqtt_ch_pkg::PH_FLAGS;
        end
        mqtt_ch_pkg::PH_FLAGS: begin
          flags_next = byte_value;
          phase_next = mqtt_ch_pkg::PH_KEEP;
          cnt_next   = '0;
          keep_next  = '0;
        end
        mqtt_ch_pkg::PH_KEEP: begin
          keep_next = {keep[7:0], byte_value};
          cnt_next  = cnt + 3'd1;
          if (cnt + 3'd1 >= mqtt_ch_pkg::KEEP_ALIVE_BYTES) begin
            phase_next = mqtt_ch_pkg::PH_PROPLEN;
            cnt_next   = '0;
            acc_next   = '0;
          end
        end
        mqtt_ch_pkg::PH_PROPLEN: begin
          acc_next = acc_merge;
          cnt_next = cnt + 3'd1;
        end
        default: begin
          phase_next = mqtt_ch_pkg::PH_DRAIN;
        end
      endcase

      // Result given: skip to end of packet, or rearm on the final byte
      if (res_fire || phase == mqtt_ch_pkg::PH_DRAIN) begin
        phase_next = mqtt_ch_pkg::PH_DRAIN;
        if (last_byte) begin
          phase_next    = mqtt_ch_pkg::PH_FIRST;
          cnt_next      = '0;
          name_bad_next = 1'b0;
        end
      end
    end
  end

  // Parse registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= mqtt_ch_pkg::PH_FIRST;
      cnt      <= '0;
      name_bad <= 1'b0;
    end else begin
      phase    <= phase_next;
      cnt      <= cnt_next;
      name_bad <= name_bad_next;
    end
    acc     <= acc_next;
    rem_len <= rem_len_next;
    version <= version_next;
    flags   <= flags_next;
    keep    <= keep_next;
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_q      <= skid_q;
        skid_valid <= 1'b0;
      end
    end else if (item_fire && res_fire) begin
      if (!out_valid || result_ready) begin
        out_q     <= res;
        out_valid <= 1'b1;
      end else begin
        skid_q     <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign result_valid       = out_valid;
  assign status             = out_q.status;
  assign protocol_version   = out_q.version;
  assign clean_start        = out_q.flags[1];
  assign will_present       = out_q.flags[2];
  assign will_qos           = out_q.flags[4:3];
  assign will_retain        = out_q.flags[5];
  assign password_present   = out_q.flags[6];
  assign username_present   = out_q.flags[7];
  assign keep_alive_seconds = out_q.keep_alive;
  assign rem_length         = out_q.rem_len;
  assign prop_length        = out_q.prop_len;

  // Skid entry is only used behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid without output valid");

  // Name index never runs past the sixth byte
  a_name_index: assert property (@(posedge clk) disable iff (rst)
    phase == mqtt_ch_pkg::PH_NAME |-> cnt <= mqtt_ch_pkg::NAME_LAST_INDEX)
    else $error("name byte index out of range");

  // Length byte count stays within four plus the overlong byte check
  a_vbi_count: assert property (@(posedge clk) disable iff (rst)
    (phase == mqtt_ch_pkg::PH_REMLEN || phase == mqtt_ch_pkg::PH_PROPLEN)
      |-> cnt <= mqtt_ch_pkg::VBI_MAX_BYTES)
    else $error("length byte count out of range");

  // No second result for a packet while skipping its tail
  a_drain_silent: assert property (@(posedge clk) disable iff (rst)
    (item_fire && phase == mqtt_ch_pkg::PH_DRAIN) |-> !res_fire)
    else $error("result produced while draining packet");

  // Error results carry zeroed fields
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != mqtt_ch_pkg::ST_OK)
      |-> (protocol_version == 8'd0 && rem_length == '0 && prop_length == '0))
    else $error("error result with nonzero fields");

endmodule
